// File: hw/rtl/modbus_rtu_slave_fn4_fn6_assert.svh
// Assertion macros for the Modbus RTU slave.
// Each expects clk and rst_n in scope.
`ifndef MODBUS_RTU_SLAVE_FN4_FN6_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FN4_FN6_ASSERT_SVH
`ifndef SYNTHESIS
`define MRTU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mrtu assertion failed");
`define MRTU_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mrtu forbidden condition");
`else
`define MRTU_ASSERT(lbl, prop)
`define MRTU_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/mrtu_pkg.sv
package mrtu_pkg;

    localparam int FRAME_BYTES   = 8;
    localparam int BANK_WORDS_DEF = 16;

    localparam logic [7:0]  FN_READ       = 8'h04;
    localparam logic [7:0]  FN_WRITE      = 8'h06;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] BANK0_RESET   = 16'h0002;

    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam logic [7:0]  GAP_TICKS_RESET  = 8'd10;

    // configuration register indexes
    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_GAP_TICKS  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_JUDGE,
        ST_HEAD,
        ST_RREQ,
        ST_RDAT,
        ST_WHI,
        ST_WLO,
        ST_CLO,
        ST_CHI
    } eng_state_t;

    // frame tracker -> engine
    typedef struct packed {
        logic                           done;
        logic [FRAME_BYTES-1:0][7:0]    bytes;
    } frame_t;

    // engine -> output register
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       last;
    } tx_t;

    // Modbus CRC-16, one byte, bit-reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/mrtu_ram.sv
module mrtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mrtu_frame.sv
module mrtu_frame
    import mrtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       is_tick,
    input  logic [7:0] rx_byte,
    input  logic [7:0] gap_ticks,
    output frame_t     frame
);

    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic [FRAME_BYTES-1:0][7:0] store_reg, store_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [7:0]     gap_reg, gap_next;
    logic           run_reg, run_next;
    logic [7:0]     gap_inc;
    logic           done;

    assign gap_inc = gap_reg + 8'd1;

    always_comb
    begin
        store_next = store_reg;
        count_next = count_reg;
        gap_next   = gap_reg;
        run_next   = run_reg;
        done       = 1'b0;
        if (accept) begin
            if (!is_tick) begin
                if (count_reg < CW'(FRAME_BYTES)) begin
                    store_next[count_reg[CW-2:0]] = rx_byte;
                    count_next = count_reg + CW'(1);
                    run_next   = 1'b1;
                end
                gap_next = 8'd0;
            end else if (run_reg) begin
                gap_next = gap_inc;
                if (gap_inc >= gap_ticks) begin
                    done       = 1'b1;
                    run_next   = 1'b0;
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            store_reg <= '0;
            count_reg <= '0;
            gap_reg   <= '0;
            run_reg   <= 1'b0;
        end else begin
            store_reg <= store_next;
            count_reg <= count_next;
            gap_reg   <= gap_next;
            run_reg   <= run_next;
        end
    end

    assign frame.done  = done;
    assign frame.bytes = store_reg;

endmodule

// File: hw/rtl/mrtu_engine.sv
`include "modbus_rtu_slave_fn4_fn6_assert.svh"
module mrtu_engine
    import mrtu_pkg::*;
#(
    parameter int BANK_WORDS = BANK_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  frame_t     frame,
    input  logic [7:0] slave_address,
    input  logic       space,
    output logic       busy,
    output tx_t        tx
);

    localparam int AW  = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
    localparam int WCW = $clog2(BANK_WORDS + 1);

    eng_state_t state_reg, state_next;
    logic [2:0]     k_reg, k_next;
    logic [15:0]    crc_reg, crc_next;
    logic [WCW-1:0] n_reg, n_next;
    logic [WCW-1:0] j_reg, j_next;
    logic [15:0]    word_reg, word_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           inr_reg, inr_next;
    logic           wr_reg, wr_next;
    logic [BANK_WORDS-1:0] valid_reg, valid_next;

    logic [7:0]  fn, b0;
    logic [15:0] addr16, val16, rx_crc;
    logic        ok, addr_ok;
    logic [16:0] idx_full;
    logic [7:0]  head_byte;
    logic [WCW-1:0] n_cap;
    logic        ram_we;
    logic [15:0] ram_rdata;

    assign b0      = frame.bytes[0];
    assign fn      = frame.bytes[1];
    assign addr16  = {frame.bytes[2], frame.bytes[3]};
    assign val16   = {frame.bytes[4], frame.bytes[5]};
    assign rx_crc  = {frame.bytes[7], frame.bytes[6]};
    assign addr_ok = addr16 < 16'(BANK_WORDS);
    assign ok      = (fn == FN_READ || fn == FN_WRITE) && crc_reg == rx_crc
                     && b0 == slave_address;
    assign n_cap   = (val16 > 16'(BANK_WORDS)) ? WCW'(BANK_WORDS) : val16[WCW-1:0];
    assign idx_full = {1'b0, addr16} + 17'(j_reg);
    assign ram_we  = state_reg == ST_JUDGE && ok && fn == FN_WRITE && addr_ok;

    always_comb
    begin
        unique case (k_reg)
            3'd0:    head_byte = slave_address;
            3'd1:    head_byte = fn;
            3'd2:    head_byte = wr_reg ? frame.bytes[2] : 8'({n_reg, 1'b0});
            default: head_byte = frame.bytes[k_reg];
        endcase
    end

    mrtu_ram #(.WIDTH(16), .DEPTH(BANK_WORDS), .AW(AW)) u_bank (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr16[AW-1:0]),
        .wdata (val16),
        .raddr (idx_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (frame.done) state_next = ST_CHECK;
            ST_CHECK: if (k_reg == 3'd5) state_next = ST_JUDGE;
            ST_JUDGE: state_next = ok ? ST_HEAD : ST_IDLE;
            ST_HEAD:
                if (space && k_reg == (wr_reg ? 3'd5 : 3'd2))
                    state_next = (wr_reg || n_reg == '0) ? ST_CLO : ST_RREQ;
            ST_RREQ:  state_next = ST_RDAT;
            ST_RDAT:  state_next = ST_WHI;
            ST_WHI:   if (space) state_next = ST_WLO;
            ST_WLO:
                if (space)
                    state_next = (j_reg + WCW'(1) == n_reg) ? ST_CLO : ST_RREQ;
            ST_CLO:   if (space) state_next = ST_CHI;
            ST_CHI:   if (space) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        k_next     = k_reg;
        crc_next   = crc_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        inr_next   = inr_reg;
        wr_next    = wr_reg;
        valid_next = valid_reg;
        tx.push    = 1'b0;
        tx.data    = 8'h00;
        tx.last    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next   = '0;
                crc_next = CRC_INIT;
            end
            ST_CHECK:
            begin
                crc_next = crc16_byte(crc_reg, frame.bytes[k_reg]);
                k_next   = k_reg + 3'd1;
            end
            ST_JUDGE:
            begin
                crc_next = CRC_INIT;
                k_next   = '0;
                j_next   = '0;
                n_next   = n_cap;
                wr_next  = fn == FN_WRITE;
                if (ram_we)
                    valid_next[addr16[AW-1:0]] = 1'b1;
            end
            ST_HEAD:
            begin
                tx.push = space;
                tx.data = head_byte;
                if (space) begin
                    crc_next = crc16_byte(crc_reg, head_byte);
                    k_next   = k_reg + 3'd1;
                end
            end
            ST_RREQ:
            begin
                idx_next = idx_full[AW-1:0];
                inr_next = idx_full < 17'(BANK_WORDS);
            end
            ST_RDAT:
            begin
                if (!inr_reg)
                    word_next = 16'h0000;
                else if (valid_reg[idx_reg])
                    word_next = ram_rdata;
                else
                    word_next = (idx_reg == '0) ? BANK0_RESET : 16'h0000;
            end
            ST_WHI:
            begin
                tx.push = space;
                tx.data = word_reg[15:8];
                if (space)
                    crc_next = crc16_byte(crc_reg, word_reg[15:8]);
            end
            ST_WLO:
            begin
                tx.push = space;
                tx.data = word_reg[7:0];
                if (space) begin
                    crc_next = crc16_byte(crc_reg, word_reg[7:0]);
                    j_next   = j_reg + WCW'(1);
                end
            end
            ST_CLO:
            begin
                tx.push = space;
                tx.data = crc_reg[7:0];
            end
            ST_CHI:
            begin
                tx.push = space;
                tx.data = crc_reg[15:8];
                tx.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        crc_reg  <= crc_next;
        n_reg    <= n_next;
        j_reg    <= j_next;
        word_reg <= word_next;
        idx_reg  <= idx_next;
        inr_reg  <= inr_next;
        wr_reg   <= wr_next;
    end

    assign busy = state_reg != ST_IDLE;

    `MRTU_ASSERT(a_rdat_after_req, state_reg == ST_RDAT |-> $past(state_reg) == ST_RREQ)
    `MRTU_NEVER(a_done_while_busy, frame.done && busy)
    `MRTU_ASSERT(a_last_ends_reply, tx.push && tx.last |=> state_reg == ST_IDLE)

endmodule

// File: hw/rtl/modbus_rtu_slave_fn4_fn6.sv
// Modbus RTU slave for function 4 (read input words) and function 6 (write
// single word). Each input transaction is a received byte (s_tuser = 0) or a
// timer tick (s_tuser = 1). Bytes fill an 8-byte frame buffer; further bytes
// are dropped and the buffer is never cleared, so short frames are checked
// against stale contents. Any byte restarts the silence count; once
// frame_gap_ticks ticks pass after the last byte the frame is checked: the
// function code must be 4 or 6, the CRC-16 over bytes 0..5 must match bytes
// 6..7, and byte 0 must equal slave_address. Replies leave on the master
// side one byte per transaction, m_tlast on the second CRC byte. The
// block stalls input while it checks and answers a frame: byte-serial CRC
// over bytes 0..5 and a judge step, then the header bytes, for each word
// read a bank RAM read request, the read data and two data bytes, then the
// two CRC bytes; the reply stalls while the output register is full and
// m_tready is low. A rejected frame gets no reply. Word bank contents after
// reset: word 0 is 2, others 0. Configuration writes are taken at any time.
module modbus_rtu_slave_fn4_fn6
    import mrtu_pkg::*;
#(
    parameter int BANK_WORDS = BANK_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration: 0 slave_address, 1 frame_gap_ticks
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    // receive side
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    input  logic [0:0] s_tuser,    // [0] func: 0 byte, 1 tick
    // reply side
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] tx_byte
    output logic       m_tlast
);

    logic [7:0] slave_addr_reg, gap_ticks_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       busy;
    logic       space;
    logic       in_accept;
    frame_t     frame;
    tx_t        tx;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
            gap_ticks_reg  <= GAP_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SLAVE_ADDR: slave_addr_reg <= cfg_data;
                REG_GAP_TICKS:  gap_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input is taken only while no frame is being answered
    assign s_tready  = !busy;
    assign in_accept = s_tvalid && s_tready;

    mrtu_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .is_tick   (s_tuser[0]),
        .rx_byte   (s_tdata),
        .gap_ticks (gap_ticks_reg),
        .frame     (frame)
    );

    mrtu_engine #(.BANK_WORDS(BANK_WORDS)) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .slave_address (slave_addr_reg),
        .space         (space),
        .busy          (busy),
        .tx            (tx)
    );

    // output register: reloads whenever empty or being drained
    assign space = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (space)
            out_valid_reg <= tx.push;
    end

    always_ff @(posedge clk)
    begin
        if (tx.push) begin
            out_data_reg <= tx.data;
            out_last_reg <= tx.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
